[design/ilha_pkg.sv]
// Shared types and constants for the implicit-list heap allocator.
// Holds the heap geometry, the command codes, the micro-operation and
// condition codes, and the structs that pass between sequencer and datapath.
package ilha_pkg;

    localparam int HEAP_WORDS = 1024;
    localparam int AW = $clog2(HEAP_WORDS);
    localparam int NW = ((AW > 14) ? AW : 14) + 1;
    localparam int TW = ((AW + 2 > 14) ? AW + 2 : 14);
    localparam int CAP_BYTES = (HEAP_WORDS * 4) & ~7;
    localparam int HEAP_BYTES_RESET = 4084;

    localparam logic [1:0] CMD_INIT     = 2'd0;
    localparam logic [1:0] CMD_ALLOC    = 2'd1;
    localparam logic [1:0] CMD_FREE     = 2'd2;
    localparam logic [1:0] CMD_COALESCE = 2'd3;

    typedef logic [4:0] t_step;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_INIT_SETUP,
        OP_CLEAR,
        OP_WR_FIRST,
        OP_WR_SENT,
        OP_ALLOC_SETUP,
        OP_RD_NXT,
        OP_RD_B,
        OP_LOAD_A,
        OP_STEP_NXT,
        OP_SET_FAIL,
        OP_HIT_WRITE,
        OP_WR_REM,
        OP_SET_NXT_FREE,
        OP_WR_DEC,
        OP_SET_NXT1,
        OP_MERGE,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_DISPATCH,
        C_CLR_MORE,
        C_NXT_GE_SENT,
        C_RD_IS_ONE,
        C_A_FITS,
        C_STEP_NONZERO,
        C_STEP_ZERO,
        C_NO_SPLIT,
        C_ADDR_LOW,
        C_RD_LOW3_ZERO
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic clr_more;
        logic nxt_ge_sent;
        logic rd_is_one;
        logic a_fits;
        logic step_zero;
        logic no_split;
        logic addr_low;
        logic rd_low3_zero;
    } t_flags;

endpackage

[design/ilha_seq.sv]
// Microcode sequencer of the heap allocator: step counter, program ROM and jumps.
// Depends on ilha_pkg for the micro-operation, condition and flag types.
module ilha_seq import ilha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_cmd,
    input  t_flags     i_flags,
    output logic       o_busy,
    output t_op        o_op
);

    localparam t_step S_IDLE = 5'd0;
    localparam t_step S_I0   = 5'd1;
    localparam t_step S_I1   = 5'd2;
    localparam t_step S_I2   = 5'd3;
    localparam t_step S_I3   = 5'd4;
    localparam t_step S_A0   = 5'd5;
    localparam t_step S_A1   = 5'd6;
    localparam t_step S_A2   = 5'd7;
    localparam t_step S_A3   = 5'd8;
    localparam t_step S_A4   = 5'd9;
    localparam t_step S_FAIL = 5'd10;
    localparam t_step S_H0   = 5'd11;
    localparam t_step S_H1   = 5'd12;
    localparam t_step S_H2   = 5'd13;
    localparam t_step S_H3   = 5'd14;
    localparam t_step S_F0   = 5'd15;
    localparam t_step S_F1   = 5'd16;
    localparam t_step S_F2   = 5'd17;
    localparam t_step S_F3   = 5'd18;
    localparam t_step S_C0   = 5'd19;
    localparam t_step S_C1   = 5'd20;
    localparam t_step S_C2   = 5'd21;
    localparam t_step S_C3   = 5'd22;
    localparam t_step S_C4   = 5'd23;
    localparam t_step S_C5   = 5'd24;
    localparam t_step S_C6   = 5'd25;
    localparam t_step S_EMIT = 5'd26;

    function automatic t_uword f_ucode(input t_step s);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        case (s)
            S_IDLE: w = '{op: OP_NOP,          cond: C_DISPATCH,     target: S_IDLE};
            S_I0:   w = '{op: OP_INIT_SETUP,   cond: C_NEVER,        target: S_IDLE};
            S_I1:   w = '{op: OP_CLEAR,        cond: C_CLR_MORE,     target: S_I1};
            S_I2:   w = '{op: OP_WR_FIRST,     cond: C_NEVER,        target: S_IDLE};
            S_I3:   w = '{op: OP_WR_SENT,      cond: C_ALWAYS,       target: S_EMIT};
            S_A0:   w = '{op: OP_ALLOC_SETUP,  cond: C_NEVER,        target: S_IDLE};
            S_A1:   w = '{op: OP_RD_NXT,       cond: C_NXT_GE_SENT,  target: S_FAIL};
            S_A2:   w = '{op: OP_LOAD_A,       cond: C_RD_IS_ONE,    target: S_FAIL};
            S_A3:   w = '{op: OP_STEP_NXT,     cond: C_A_FITS,       target: S_H0};
            S_A4:   w = '{op: OP_NOP,          cond: C_STEP_NONZERO, target: S_A1};
            S_FAIL: w = '{op: OP_SET_FAIL,     cond: C_ALWAYS,       target: S_EMIT};
            S_H0:   w = '{op: OP_HIT_WRITE,    cond: C_NEVER,        target: S_IDLE};
            S_H1:   w = '{op: OP_RD_B,         cond: C_NO_SPLIT,     target: S_EMIT};
            S_H2:   w = '{op: OP_NOP,          cond: C_RD_IS_ONE,    target: S_EMIT};
            S_H3:   w = '{op: OP_WR_REM,       cond: C_ALWAYS,       target: S_EMIT};
            S_F0:   w = '{op: OP_SET_NXT_FREE, cond: C_ADDR_LOW,     target: S_EMIT};
            S_F1:   w = '{op: OP_RD_NXT,       cond: C_NXT_GE_SENT,  target: S_EMIT};
            S_F2:   w = '{op: OP_NOP,          cond: C_RD_LOW3_ZERO, target: S_EMIT};
            S_F3:   w = '{op: OP_WR_DEC,       cond: C_ALWAYS,       target: S_EMIT};
            S_C0:   w = '{op: OP_SET_NXT1,     cond: C_NEVER,        target: S_IDLE};
            S_C1:   w = '{op: OP_RD_NXT,       cond: C_NXT_GE_SENT,  target: S_EMIT};
            S_C2:   w = '{op: OP_LOAD_A,       cond: C_NEVER,        target: S_IDLE};
            S_C3:   w = '{op: OP_STEP_NXT,     cond: C_STEP_ZERO,    target: S_EMIT};
            S_C4:   w = '{op: OP_RD_B,         cond: C_NXT_GE_SENT,  target: S_EMIT};
            S_C5:   w = '{op: OP_MERGE,        cond: C_RD_IS_ONE,    target: S_EMIT};
            S_C6:   w = '{op: OP_STEP_NXT,     cond: C_STEP_NONZERO, target: S_C4};
            S_EMIT: w = '{op: OP_EMIT,         cond: C_ALWAYS,       target: S_IDLE};
            default: w = '{op: OP_NOP,         cond: C_ALWAYS,       target: S_IDLE};
        endcase
        return w;
    endfunction

    t_step  r_step;
    t_step  n_step;
    t_step  w_entry;
    t_uword w_uword;
    logic   w_take;

    assign w_uword = f_ucode(r_step);
    assign o_op    = w_uword.op;
    assign o_busy  = (r_step != S_IDLE);

    always_comb begin
        unique case (i_cmd)
            CMD_INIT:     w_entry = S_I0;
            CMD_ALLOC:    w_entry = S_A0;
            CMD_FREE:     w_entry = S_F0;
            CMD_COALESCE: w_entry = S_C0;
        endcase
    end

    always_comb begin
        unique case (w_uword.cond)
            C_NEVER:        w_take = 1'b0;
            C_ALWAYS:       w_take = 1'b1;
            C_DISPATCH:     w_take = 1'b0;
            C_CLR_MORE:     w_take = i_flags.clr_more;
            C_NXT_GE_SENT:  w_take = i_flags.nxt_ge_sent;
            C_RD_IS_ONE:    w_take = i_flags.rd_is_one;
            C_A_FITS:       w_take = i_flags.a_fits;
            C_STEP_NONZERO: w_take = !i_flags.step_zero;
            C_STEP_ZERO:    w_take = i_flags.step_zero;
            C_NO_SPLIT:     w_take = i_flags.no_split;
            C_ADDR_LOW:     w_take = i_flags.addr_low;
            C_RD_LOW3_ZERO: w_take = i_flags.rd_low3_zero;
            default:        w_take = 1'b1;
        endcase
    end

    always_comb begin
        if (w_uword.cond == C_DISPATCH) begin
            n_step = start ? w_entry : S_IDLE;
        end else if (w_take) begin
            n_step = w_uword.target;
        end else begin
            n_step = r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_I0;
        end else begin
            r_step <= n_step;
        end
    end

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_IDLE && !start) |=> (r_step == S_IDLE))
        else $error("Sequencer left idle without a start.");

    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_EMIT) |=> (r_step == S_IDLE))
        else $error("Sequencer did not return to idle after the result.");

endmodule

[design/ilha_dp.sv]
// Datapath of the heap allocator: heap memory, walk registers, config and result.
// Depends on ilha_pkg; driven one micro-operation per cycle by ilha_seq.
module ilha_dp import ilha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic        i_accept,
    input  logic [11:0] i_length,
    input  logic [11:0] i_address,
    input  logic        i_cfg_wr_en,
    input  logic [11:0] i_cfg_wr_data,
    output t_flags      o_flags,
    output logic        o_strobe,
    output logic        o_status,
    output logic [11:0] o_payload_offset
);

    logic [15:0]   mem [HEAP_WORDS];

    logic [11:0]   r_heap_bytes;
    logic [11:0]   r_length;
    logic [11:0]   r_address;
    logic [AW-1:0] r_sent;
    logic [12:0]   r_size;
    logic [AW-1:0] r_idx;
    logic [NW-1:0] r_nxt;
    logic [15:0]   r_a;
    logic [15:0]   r_rd;
    logic [AW-1:0] r_clr;
    logic          r_status;
    logic [11:0]   r_off;
    logic          r_pending;
    logic          r_valid;

    logic [TW-1:0] w_total_raw;
    logic [TW-1:0] w_total;
    logic [AW-1:0] w_sent_next;
    logic [12:0]   w_size_next;
    logic [11:0]   w_off_hit;
    logic          w_nxt_ge_sent;
    logic          w_both_free;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic          w_re;

    assign w_total_raw = (TW'(r_heap_bytes) + TW'(19)) & ~TW'(7);
    assign w_total     = (w_total_raw > TW'(CAP_BYTES)) ? TW'(CAP_BYTES) : w_total_raw;
    assign w_sent_next = AW'(w_total[TW-1:2] - 1'b1);
    assign w_size_next = (13'(r_length) + 13'd11) & ~13'd7;
    assign w_off_hit   = 12'((NW'(r_idx) + NW'(1)) << 2);
    assign w_nxt_ge_sent = (r_nxt >= NW'(r_sent));
    assign w_both_free   = !r_a[0] && !r_rd[0];

    assign o_flags.clr_more     = (r_clr != AW'(HEAP_WORDS - 1));
    assign o_flags.nxt_ge_sent  = w_nxt_ge_sent;
    assign o_flags.rd_is_one    = (r_rd == 16'd1);
    assign o_flags.a_fits       = !r_a[0] && (r_a >= 16'(r_size));
    assign o_flags.step_zero    = (r_a[15:2] == 14'd0);
    assign o_flags.no_split     = !((r_a > 16'(r_size)) && !w_nxt_ge_sent);
    assign o_flags.addr_low     = (r_address[11:3] == 9'd0);
    assign o_flags.rd_low3_zero = (r_rd[2:0] == 3'd0);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = 16'd0;
        w_re    = 1'b0;
        unique case (i_op)
            OP_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            OP_WR_FIRST: begin
                w_we    = 1'b1;
                w_waddr = AW'(1);
                w_wdata = r_a;
            end
            OP_WR_SENT: begin
                w_we    = 1'b1;
                w_waddr = r_sent;
                w_wdata = 16'd1;
            end
            OP_HIT_WRITE: begin
                w_we    = 1'b1;
                w_wdata = 16'(r_size) + 16'd1;
            end
            OP_WR_REM: begin
                w_we    = 1'b1;
                w_waddr = r_nxt[AW-1:0];
                w_wdata = r_a - 16'(r_size);
            end
            OP_WR_DEC: begin
                w_we    = 1'b1;
                w_wdata = r_rd - 16'd1;
            end
            OP_MERGE: begin
                w_we    = w_both_free;
                w_wdata = r_a + r_rd;
            end
            OP_RD_NXT, OP_RD_B: begin
                w_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we && i_rst_n) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= mem[r_nxt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_length  <= i_length;
            r_address <= i_address;
            r_status  <= 1'b0;
            r_off     <= 12'd0;
        end
        unique case (i_op)
            OP_INIT_SETUP: begin
                r_sent <= w_sent_next;
                r_a    <= 16'(w_total - TW'(8));
                r_clr  <= '0;
            end
            OP_CLEAR:        r_clr <= r_clr + 1'b1;
            OP_ALLOC_SETUP: begin
                r_size <= w_size_next;
                r_nxt  <= NW'(1);
            end
            OP_SET_NXT1:     r_nxt <= NW'(1);
            OP_RD_NXT:       r_idx <= r_nxt[AW-1:0];
            OP_LOAD_A:       r_a   <= r_rd;
            OP_STEP_NXT:     r_nxt <= NW'(r_idx) + NW'(r_a[15:2]);
            OP_SET_FAIL: begin
                r_status <= 1'b1;
                r_off    <= 12'd0;
            end
            OP_HIT_WRITE: begin
                r_off <= w_off_hit;
                r_nxt <= NW'(r_idx) + NW'(r_size[12:2]);
            end
            OP_SET_NXT_FREE: r_nxt <= NW'(r_address[11:2]) - NW'(1);
            OP_MERGE: begin
                if (w_both_free) begin
                    r_a <= r_a + r_rd;
                end else begin
                    r_idx <= r_nxt[AW-1:0];
                    r_a   <= r_rd;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_bytes <= 12'(HEAP_BYTES_RESET);
            r_pending    <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_heap_bytes <= i_cfg_wr_data;
            end
            r_valid <= (i_op == OP_EMIT) && r_pending;
            if (i_accept) begin
                r_pending <= 1'b1;
            end else if (i_op == OP_EMIT) begin
                r_pending <= 1'b0;
            end
        end
    end

    assign o_strobe         = r_valid;
    assign o_status         = r_status;
    assign o_payload_offset = r_off;

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_op == OP_EMIT))
        else $error("Result word shown without a completed command.");

    a_fail_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status) |-> (r_off == 12'd0))
        else $error("Failed allocation carries a nonzero offset.");

    a_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_pending)
        else $error("Accepted command not marked pending.");

endmodule

[design/implicit_list_heap_allocator.sv]
// Top level of the implicit-list first-fit heap allocator.
// Instantiates ilha_seq (microcode sequencer) and ilha_dp (datapath and heap memory).
//
// A command word (i_cmd, i_length, i_address) is taken at a clock edge where start
// is high and busy is low. Commands: init heap, allocate, free, coalesce.
// Every command gives exactly one result word on o_status and o_payload_offset,
// marked by o_strobe for one cycle; the receiver cannot hold it off. busy drops
// in the cycle the strobe is high, so a new command may be given right then.
// The work of each command is set by the microcode steps and the single read port
// of the heap memory: init clears one memory word per cycle and then writes the
// layout, allocate walks the block headers until one fits or none does, and
// coalesce steps over header pairs.
// The heap size register is written through i_cfg_wr_en and i_cfg_wr_data at
// any edge while idle, a rule for the user that the block itself does not
// enforce; the value takes effect at the next init. Reset (synchronous, active
// low) sets the heap size to 4084 and runs an init, holding busy high until it
// is done; no result word is given for it.
module implicit_list_heap_allocator import ilha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_length,
    input  logic [11:0] i_address,
    input  logic        i_cfg_wr_en,
    input  logic [11:0] i_cfg_wr_data,
    output logic        o_strobe,
    output logic        o_status,
    output logic [11:0] o_payload_offset
);

    t_op    w_op;
    t_flags w_flags;
    logic   w_accept;

    assign w_accept = start && !busy;

    ilha_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_flags (w_flags),
        .o_busy  (busy),
        .o_op    (w_op)
    );

    ilha_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .i_accept         (w_accept),
        .i_length         (i_length),
        .i_address        (i_address),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_flags          (w_flags),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset)
    );

endmodule

[dv/ilha_reply_check.sv]
`timescale 1ns / 100ps
// Checker for the implicit-list heap allocator: keeps its own copy of the heap
// and the size register, predicts each result word and compares it on o_strobe.
// Depends on ilha_pkg for the command codes and the heap geometry.
module ilha_reply_check import ilha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_length,
    input  logic [11:0] i_address,
    input  logic        i_cfg_wr_en,
    input  logic [11:0] i_cfg_wr_data,
    input  logic        o_strobe,
    input  logic        o_status,
    input  logic [11:0] o_payload_offset,
    output int          fail_count,
    output int          words_pending
);

    typedef struct packed {
        logic        status;
        logic [11:0] offset;
    } t_reply;

    logic [15:0]  heap_mem [HEAP_WORDS];
    int unsigned  sentinel_idx;
    logic [11:0]  heap_size_reg;
    t_reply       owed_replies [$];
    int           fails;

    assign fail_count = fails;

    initial begin
        words_pending = 0;
    end

    function automatic void lay_heap();
        int unsigned total;
        total = (32'(heap_size_reg) + 32'd19) & ~32'd7;
        if (total > CAP_BYTES) begin
            total = CAP_BYTES;
        end
        for (int i = 0; i < HEAP_WORDS; i++) begin
            heap_mem[i] = 16'd0;
        end
        sentinel_idx = total / 4 - 1;
        heap_mem[1] = 16'(total - 8);
        heap_mem[sentinel_idx] = 16'd1;
    endfunction

    function automatic t_reply heap_alloc(input logic [11:0] want);
        int unsigned fit;
        int unsigned idx;
        int unsigned stride;
        int unsigned old_hdr;
        int unsigned nxt;
        logic [15:0] hdr;
        logic        found;
        logic        done;
        t_reply      r;
        fit = (32'(want) + 32'd11) & ~32'd7;
        idx = 1;
        found = 1'b0;
        done = 1'b0;
        r = '0;
        while (!done) begin
            if (idx >= sentinel_idx) begin
                done = 1'b1;
            end else begin
                hdr = heap_mem[idx];
                if (hdr == 16'd1) begin
                    done = 1'b1;
                end else if (!hdr[0] && 32'(hdr) >= fit) begin
                    found = 1'b1;
                    done = 1'b1;
                end else begin
                    stride = 32'(hdr) >> 2;
                    if (stride == 0) begin
                        done = 1'b1;
                    end else begin
                        idx = idx + stride;
                    end
                end
            end
        end
        if (found) begin
            old_hdr = 32'(heap_mem[idx]);
            heap_mem[idx] = 16'(fit + 1);
            r.offset = 12'((idx + 1) * 4);
            nxt = idx + fit / 4;
            if (old_hdr > fit && nxt < sentinel_idx && heap_mem[nxt] != 16'd1) begin
                heap_mem[nxt] = 16'(old_hdr - fit);
            end
        end else begin
            r.status = 1'b1;
        end
        return r;
    endfunction

    function automatic void heap_free(input logic [11:0] addr);
        int unsigned w;
        w = 32'(addr) >> 2;
        if (w >= 2 && w - 1 < sentinel_idx && heap_mem[w - 1][2:0] != 3'd0) begin
            heap_mem[w - 1] = heap_mem[w - 1] - 16'd1;
        end
    endfunction

    function automatic void heap_coalesce();
        int unsigned idx;
        int unsigned stride;
        int unsigned nxt;
        logic [15:0] a;
        logic [15:0] b;
        logic        stop;
        idx = 1;
        stop = (idx >= sentinel_idx);
        if (!stop) begin
            stride = 32'(heap_mem[idx]) >> 2;
            stop = (stride == 0);
            nxt = idx + stride;
        end
        while (!stop && nxt < sentinel_idx && heap_mem[nxt] != 16'd1) begin
            a = heap_mem[idx];
            b = heap_mem[nxt];
            if (!a[0] && !b[0]) begin
                heap_mem[idx] = a + b;
            end else begin
                idx = nxt;
            end
            stride = 32'(heap_mem[idx]) >> 2;
            if (stride == 0) begin
                stop = 1'b1;
            end else begin
                nxt = idx + stride;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            heap_size_reg = 12'(HEAP_BYTES_RESET);
            lay_heap();
            owed_replies.delete();
            fails = 0;
        end else begin
            if (o_strobe) begin
                got.status = o_status;
                got.offset = o_payload_offset;
                if (owed_replies.size() == 0) begin
                    $error("result word with none expected: status %0d, payload_offset %0d",
                           got.status, got.offset);
                    fails++;
                end else begin
                    want = owed_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fails++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("payload_offset mismatch: expected %0d, actual %0d",
                               want.offset, got.offset);
                        fails++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                heap_size_reg = i_cfg_wr_data;
            end
            if (start && !busy) begin
                want = '0;
                case (i_cmd)
                    CMD_INIT: begin
                        lay_heap();
                    end
                    CMD_ALLOC: begin
                        want = heap_alloc(i_length);
                    end
                    CMD_FREE: begin
                        heap_free(i_address);
                    end
                    default: begin
                        heap_coalesce();
                    end
                endcase
                owed_replies.push_back(want);
            end
        end
        words_pending = owed_replies.size();
    end

endmodule

[dv/implicit_list_heap_allocator_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the implicit-list heap allocator: drives directed and random
// command words and heap size writes, and gives the verdict from ilha_reply_check.
// Depends on ilha_pkg, implicit_list_heap_allocator and ilha_reply_check.
module implicit_list_heap_allocator_tb;
    import ilha_pkg::*;

    localparam int TOTAL_WORDS = 1170;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [11:0] i_length;
    logic [11:0] i_address;
    logic        i_cfg_wr_en;
    logic [11:0] i_cfg_wr_data;
    logic        o_strobe;
    logic        o_status;
    logic [11:0] o_payload_offset;
    int          fail_count;
    int          words_pending;
    int          words_sent;
    int          stall_cycles;
    logic        no_gaps;
    logic [11:0] live_payloads [$];

    implicit_list_heap_allocator DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_length(i_length),
        .i_address(i_address),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_payload_offset(o_payload_offset)
    );

    ilha_reply_check u_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_length(i_length),
        .i_address(i_address),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_payload_offset(o_payload_offset),
        .fail_count(fail_count),
        .words_pending(words_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (o_strobe && o_payload_offset != 12'd0) begin
            live_payloads.push_back(o_payload_offset);
            if (live_payloads.size() > 64) begin
                void'(live_payloads.pop_front());
            end
        end
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic issue(input logic [1:0] c, input logic [11:0] len, input logic [11:0] addr);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        i_length <= len;
        i_address <= addr;
        do @(posedge i_clk); while (busy);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (words_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_heap(input logic [11:0] heap_bytes);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= heap_bytes;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        issue(CMD_INIT, 12'($urandom), 12'($urandom));
    endtask

    function automatic logic [11:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 12'($urandom_range(0, 127));
        end else if (r < 92) begin
            return 12'($urandom_range(0, 1023));
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [11:0] pick_heap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return 12'($urandom_range(0, 255));
        end else if (r < 70) begin
            return 12'($urandom_range(0, 4084));
        end else if (r < 85) begin
            return 12'(HEAP_BYTES_RESET);
        end else if (r < 93) begin
            return 12'($urandom_range(4085, 4095));
        end
        return 12'd0;
    endfunction

    function automatic logic [11:0] pick_free_address();
        int k;
        logic [11:0] a;
        if (live_payloads.size() == 0 || $urandom_range(0, 99) < 25) begin
            return 12'($urandom_range(0, 4095));
        end
        k = $urandom_range(0, live_payloads.size() - 1);
        a = live_payloads[k];
        if ($urandom_range(0, 3) != 0) begin
            live_payloads.delete(k);
        end
        if ($urandom_range(0, 9) == 0) begin
            a[1:0] = 2'($urandom_range(0, 3));
        end
        return a;
    endfunction

    initial begin
        int r;
        int phase_len;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = CMD_INIT;
        i_length = 12'd0;
        i_address = 12'd0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 12'd0;
        stall_cycles = 0;
        words_sent = 0;
        no_gaps = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(CMD_ALLOC, 12'd0, 12'd0);
        issue(CMD_ALLOC, 12'd4095, 12'd0);
        issue(CMD_FREE, 12'd0, 12'd8);
        issue(CMD_FREE, 12'd0, 12'd0);
        issue(CMD_FREE, 12'd0, 12'd4);
        issue(CMD_COALESCE, 12'd0, 12'd0);
        issue(CMD_ALLOC, 12'd4084, 12'd0);
        issue(CMD_ALLOC, 12'd1, 12'd0);
        issue(CMD_FREE, 12'd4095, 12'd11);
        issue(CMD_ALLOC, 12'd100, 12'd0);
        issue(CMD_ALLOC, 12'd200, 12'd0);
        issue(CMD_FREE, 12'd0, 12'd8);
        issue(CMD_ALLOC, 12'd40, 12'd0);
        issue(CMD_FREE, 12'd0, 12'd112);
        issue(CMD_FREE, 12'd0, 12'd4095);
        issue(CMD_COALESCE, 12'd0, 12'd0);
        set_heap(12'd0);
        issue(CMD_ALLOC, 12'd0, 12'd0);
        issue(CMD_FREE, 12'd0, 12'd16);
        issue(CMD_FREE, 12'd0, 12'd12);
        issue(CMD_ALLOC, 12'd0, 12'd0);
        set_heap(12'd4095);
        issue(CMD_ALLOC, 12'd4087, 12'd0);
        issue(CMD_ALLOC, 12'd4084, 12'd0);

        while (words_sent < TOTAL_WORDS) begin
            set_heap(pick_heap());
            live_payloads.delete();
            no_gaps = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(40, 100);
            for (int n = 0; n < phase_len && words_sent < TOTAL_WORDS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    issue(CMD_INIT, 12'($urandom), 12'($urandom));
                end else if (r < 50) begin
                    issue(CMD_ALLOC, pick_length(), 12'($urandom));
                end else if (r < 85) begin
                    issue(CMD_FREE, 12'($urandom), pick_free_address());
                end else begin
                    issue(CMD_COALESCE, 12'($urandom), 12'($urandom));
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
